[src/brr_pkg.sv]
// Package for the BLE resolvable private address resolver.
// Holds AES types, the S-box and round helper functions. No dependencies.
package brr_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned HashW = 24;
  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [127:0] block_t;
  typedef logic [7:0] byte_t;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegIrkLow = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIrkHigh = 2'd1;

  localparam byte_t [0:255] SboxTab = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants for rounds one to ten.
  localparam byte_t [1:10] RconTab = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte k of a block, AES byte order (byte 0 in the top bits).
  function automatic byte_t get_byte(input block_t b, input int unsigned k);
    get_byte = b[127-8*k -: 8];
  endfunction

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one.
  function automatic block_t next_key(input block_t k, input byte_t rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SboxTab[w3[23:16]] ^ rcon, SboxTab[w3[15:8]], SboxTab[w3[7:0]],
         SboxTab[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // One cipher round: SubBytes, ShiftRows, optional MixColumns, key add.
  function automatic block_t aes_round(input block_t s, input block_t k, input logic last);
    block_t t, m;
    byte_t a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SboxTab[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);
      a1 = get_byte(t, 4*c+1);
      a2 = get_byte(t, 4*c+2);
      a3 = get_byte(t, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      m[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      m[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      m[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    aes_round = (last ? t : m) ^ k;
  endfunction

endpackage

[src/brr_if.sv]
// Valid/ready channel interface for the resolver.
// Depends on nothing; width is a parameter.
interface brr_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/brr_round_stage.sv]
// One pipeline stage of the AES-128 datapath: a round and its key step.
// Depends on brr_pkg.
module brr_round_stage #(
  parameter int unsigned RoundNum = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld_in,
  input  brr_pkg::block_t st_in,
  input  brr_pkg::block_t key_in,
  input  logic [23:0]     hash_in,
  output logic            vld_r,
  output brr_pkg::block_t st_r,
  output brr_pkg::block_t key_r,
  output logic [23:0]     hash_r
);
  import brr_pkg::*;

  block_t key_nxt;

  // Round key for this round, derived from the previous one.
  assign key_nxt = next_key(key_in, RconTab[RoundNum]);

  // Control: valid bit moves whenever the pipe advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= aes_round(st_in, key_nxt, RoundNum == Rounds);
      key_r  <= key_nxt;
      hash_r <= hash_in;
    end
  end
endmodule

[src/ble_rpa_resolver_unit.sv]
// BLE resolvable private address resolver, AES-128 unrolled pipeline.
// Pipeline: one entry stage, then ten round stages, each registered.
// Throughput: one address per cycle; the whole pipe stalls as one when the
// output is held, so the input ready follows the output ready directly.
// Reset: rst_n synchronous active low clears valid bits and both IRK halves.
module ble_rpa_resolver_unit (
  input logic clk,
  input logic rst_n,
  brr_if.sink   in_ch,
  brr_if.source out_ch,
  brr_if.sink   cfg_ch
);
  import brr_pkg::*;

  logic [63:0] irk_lo_r, irk_hi_r;
  logic        adv;
  logic        v [0:Rounds];
  block_t      st [0:Rounds];
  block_t      ky [0:Rounds];
  logic [23:0] hs [0:Rounds];
  logic [23:0] prand;
  block_t      key0;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irk_lo_r <= '0;
      irk_hi_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data[64 +: CfgIdxW] == RegIrkLow) begin
        irk_lo_r <= cfg_ch.data[63:0];
      end else if (cfg_ch.data[64 +: CfgIdxW] == RegIrkHigh) begin
        irk_hi_r <= cfg_ch.data[63:0];
      end
    end
  end

  // The pipe advances when the last stage is empty or being taken.
  assign adv = !v[Rounds] || out_ch.ready;
  assign in_ch.ready = adv;
  assign key0 = {irk_hi_r, irk_lo_r};
  assign prand = in_ch.data[47:24];

  // Entry stage: initial key addition.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {104'd0, prand} ^ key0;
      ky[0] <= key0;
      hs[0] <= in_ch.data[23:0];
    end
  end

  // Ten round stages.
  for (genvar g = 1; g <= Rounds; g++) begin : g_rnd
    brr_round_stage #(.RoundNum(g)) u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(v[g-1]),
      .st_in(st[g-1]), .key_in(ky[g-1]), .hash_in(hs[g-1]),
      .vld_r(v[g]), .st_r(st[g]), .key_r(ky[g]), .hash_r(hs[g])
    );
  end

  // Result beat: match flag in bit 24, computed hash below.
  assign out_ch.valid = v[Rounds];
  assign out_ch.data = {st[Rounds][23:0] == hs[Rounds], st[Rounds][23:0]};
endmodule

[src/brr_checker.sv]
// Port-level checker for the resolver, bound to the top level.
// Depends on brr_if through the top level's ports.
module brr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_data
);
  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  // Input is stalled only while a result waits.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");
  // No result comes out soon after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind ble_rpa_resolver_unit brr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

[tb/tb_ble_rpa_resolver_unit.sv]
// Testbench for the BLE resolvable private address resolver.
// Depends on brr_pkg and brr_if; checks every result against an AES-128 hash predictor.
`timescale 1ns / 1ps
module tb_ble_rpa_resolver_unit;
  import brr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  brr_if #(.W(AddrW)) in_ch ();
  brr_if #(.W(HashW + 1)) out_ch ();
  brr_if #(.W(CfgIdxW + 64)) cfg_ch ();

  ble_rpa_resolver_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  typedef struct packed {
    logic             hit;
    logic [HashW-1:0] hash;
  } rpa_result_t;

  // Key as the block sees it, and the hashes still to come out.
  logic [63:0]  key_low = '0;
  logic [63:0]  key_high = '0;
  rpa_result_t  pending_hashes[$];
  int unsigned  errors = 0;
  int unsigned  beats_sent = 0;
  int unsigned  beats_checked = 0;
  int unsigned  matches_seen = 0;
  bit           idling_on = 1'b1;

  always #1 clk = ~clk;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Low 24 bits of AES-128 over 104 zero bits and prand, keyed with the IRK.
  function automatic logic [HashW-1:0] rpa_hash(input logic [127:0] key,
                                                input logic [23:0] prand);
    logic [7:0] sched[176];
    logic [7:0] st[16];
    logic [7:0] sub[16];
    logic [7:0] w[4];
    logic [7:0] rc, first, b0, b1, b2, b3, sum;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) sched[i] = key[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = sched[i-4+j];
      if (i % 16 == 0) begin
        first = w[0];
        w[0] = SboxTab[w[1]] ^ rc;
        w[1] = SboxTab[w[2]];
        w[2] = SboxTab[w[3]];
        w[3] = SboxTab[first];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      for (int j = 0; j < 4; j++) sched[i+j] = sched[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] = (i == 13) ? prand[23:16] :
                                         (i == 14) ? prand[15:8] :
                                         (i == 15) ? prand[7:0] : 8'h00;
    for (int i = 0; i < 16; i++) st[i] ^= sched[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) sub[r+4*c] = SboxTab[st[r+4*((c+r)%4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          b0 = sub[4*c]; b1 = sub[4*c+1]; b2 = sub[4*c+2]; b3 = sub[4*c+3];
          sum = b0 ^ b1 ^ b2 ^ b3;
          st[4*c]   = b0 ^ sum ^ gf_double(b0 ^ b1);
          st[4*c+1] = b1 ^ sum ^ gf_double(b1 ^ b2);
          st[4*c+2] = b2 ^ sum ^ gf_double(b2 ^ b3);
          st[4*c+3] = b3 ^ sum ^ gf_double(b3 ^ b0);
        end
      end else begin
        st = sub;
      end
      for (int i = 0; i < 16; i++) st[i] ^= sched[16*rnd+i];
    end
    return {st[13], st[14], st[15]};
  endfunction

  function automatic int unsigned draw_gap();
    return idling_on ? $urandom_range(17, 0) : 0;
  endfunction

  // Initial levels of every driven input.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Sends one address and records the result it should give.
  task automatic send_address(input logic [AddrW-1:0] addr);
    int unsigned gap;
    logic [HashW-1:0] h;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= addr;
    do @(posedge clk); while (!in_ch.ready);
    h = rpa_hash({key_high, key_low}, addr[47:24]);
    pending_hashes.push_back('{hit: (h == addr[23:0]), hash: h});
    beats_sent++;
  endtask

  // Address whose hash field agrees with the current key.
  task automatic send_resolvable(input logic [23:0] prand);
    send_address({prand, rpa_hash({key_high, key_low}, prand)});
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Register write; only issued with the pipe empty. The caller drops valid.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= {idx, value};
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == RegIrkLow) key_low = value;
    else if (idx == RegIrkHigh) key_high = value;
  endtask

  task automatic set_key(input logic [63:0] high, input logic [63:0] low);
    wait_drained();
    write_reg(RegIrkHigh, high);
    write_reg(RegIrkLow, low);
    cfg_ch.valid <= 1'b0;
  endtask

  // Zero key after reset, with the address field extremes.
  task automatic test_zero_key();
    send_address('0);
    send_address('1);
    send_address(48'hC00000_000000);
    send_address(48'h3FFFFF_FFFFFF);
    send_address(48'h000000_FFFFFF);
    send_address(48'hFFFFFF_000000);
    send_resolvable(24'h000000);
    send_resolvable(24'hFFFFFF);
    send_resolvable(24'h400001);
  endtask

  // Key extremes and a known-style key, with hits and misses.
  task automatic test_key_extremes();
    set_key('1, '1);
    send_address('1);
    send_resolvable(24'h5A5A5A);
    send_address(48'h800000_000001);
    set_key(64'h0, 64'h1);
    send_resolvable(24'h708194);
    send_address(48'h708194_000000);
    set_key(64'h8000_0000_0000_0000, 64'h0);
    send_resolvable(24'hFFFFFF);
    send_address(48'h123456_ABCDEF);
    set_key(64'hEC02_34A3_57C8_AD05, 64'h3419_1AB0_05A7_D3A1);
    send_resolvable(24'h94_81_70);
    send_address(48'h948170_000001);
  endtask

  // Random keys, with resolvable and random addresses in about equal share.
  task automatic test_random_traffic(input int unsigned n_items);
    logic [47:0] addr;
    for (int k = 0; k < 4; k++) begin
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      for (int i = 0; i < n_items / 4; i++) begin
        if (i % 40 == 0) idling_on = ($urandom_range(3, 0) != 0);
        if (i == n_items / 8) wait_drained();
        addr = 48'({$urandom, $urandom});
        if ($urandom_range(1, 0)) send_resolvable(addr[47:24]);
        else send_address(addr);
      end
    end
    idling_on = 1'b1;
  endtask

  // Result sink with random back-pressure.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    rpa_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_hashes.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: match flag expected %b actual %b", $time, want.hit,
                   got.hit);
          errors++;
        end
        if (got.hash !== want.hash) begin
          $display("%0t: hash expected %h actual %h", $time, want.hash, got.hash);
          errors++;
        end
        if (want.hit) matches_seen++;
      end
      beats_checked++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_key();
    test_key_extremes();
    test_random_traffic(600);
    wait_drained();
    $display("Checked %0d result beats from %0d addresses, %0d of them resolved.",
             beats_checked, beats_sent, matches_seen);
    if (errors == 0 && pending_hashes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_hashes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
